// File: hdl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types, constants and helpers of the two-heap running median.
// ----------------------------------------------------------------------------
package rmth_pkg;

   localparam int DEFAULT_HEAP_DEPTH = 512;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PLAN,
      S_P_INIT,
      S_P_CHECK,
      S_P_CMP,
      S_D_LEFT,
      S_D_RIGHT,
      S_D_RCMP,
      S_D_MOVE,
      S_D_END,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      C_NONE,
      C_LOAD,
      C_PLAN,
      C_PUSH_INIT,
      C_PUSH_CHECK,
      C_PUSH_CMP,
      C_SD_LEFT,
      C_SD_RIGHT,
      C_SD_RCMP,
      C_SD_MOVE,
      C_SWITCH,
      C_OUT
   } cmd_type;

   typedef struct packed {
      logic full;
      logic swap;
      logic idx_zero;
      logic up_move;
      logic left_in;
      logic right_in;
      logic best_moved;
      logic two_phase;
      logic out_free;
   } status_type;

   // True if a belongs above b: max-heap order when is_max is set.
   function automatic logic ranks_above(input logic signed [VALUE_W-1:0] a,
                                        input logic signed [VALUE_W-1:0] b,
                                        input logic is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

endpackage

// File: hdl/rmth_ram.sv
// ----------------------------------------------------------------------------
// rmth_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/rmth_ctrl.sv
// ----------------------------------------------------------------------------
// rmth_ctrl
// Sequencer for placement, sift-down, sift-up and result transfer.
// ----------------------------------------------------------------------------
module rmth_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rmth_pkg::status_type status,
   output rmth_pkg::cmd_type    cmd
);

   rmth_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmth_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmth_pkg::S_IDLE: begin
            if (req_valid) state_in = rmth_pkg::S_PLAN;
         end
         rmth_pkg::S_PLAN: begin
            if (status.full) state_in = rmth_pkg::S_DONE;
            else if (status.swap) state_in = rmth_pkg::S_D_LEFT;
            else state_in = rmth_pkg::S_P_INIT;
         end
         rmth_pkg::S_P_INIT: state_in = rmth_pkg::S_P_CHECK;
         rmth_pkg::S_P_CHECK: begin
            state_in = status.idx_zero ? rmth_pkg::S_DONE : rmth_pkg::S_P_CMP;
         end
         rmth_pkg::S_P_CMP: begin
            state_in = status.up_move ? rmth_pkg::S_P_CHECK : rmth_pkg::S_DONE;
         end
         rmth_pkg::S_D_LEFT: begin
            state_in = status.left_in ? rmth_pkg::S_D_RIGHT : rmth_pkg::S_D_END;
         end
         rmth_pkg::S_D_RIGHT: begin
            state_in = status.right_in ? rmth_pkg::S_D_RCMP : rmth_pkg::S_D_MOVE;
         end
         rmth_pkg::S_D_RCMP: state_in = rmth_pkg::S_D_MOVE;
         rmth_pkg::S_D_MOVE: begin
            state_in = status.best_moved ? rmth_pkg::S_D_LEFT : rmth_pkg::S_D_END;
         end
         rmth_pkg::S_D_END: begin
            state_in = status.two_phase ? rmth_pkg::S_P_INIT : rmth_pkg::S_DONE;
         end
         rmth_pkg::S_DONE: begin
            if (status.out_free) state_in = rmth_pkg::S_IDLE;
         end
         default: state_in = rmth_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = rmth_pkg::C_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         rmth_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd = rmth_pkg::C_LOAD;
         end
         rmth_pkg::S_PLAN:    cmd = rmth_pkg::C_PLAN;
         rmth_pkg::S_P_INIT:  cmd = rmth_pkg::C_PUSH_INIT;
         rmth_pkg::S_P_CHECK: cmd = rmth_pkg::C_PUSH_CHECK;
         rmth_pkg::S_P_CMP:   cmd = rmth_pkg::C_PUSH_CMP;
         rmth_pkg::S_D_LEFT:  cmd = rmth_pkg::C_SD_LEFT;
         rmth_pkg::S_D_RIGHT: cmd = rmth_pkg::C_SD_RIGHT;
         rmth_pkg::S_D_RCMP:  cmd = rmth_pkg::C_SD_RCMP;
         rmth_pkg::S_D_MOVE:  cmd = rmth_pkg::C_SD_MOVE;
         rmth_pkg::S_D_END: begin
            if (status.two_phase) cmd = rmth_pkg::C_SWITCH;
         end
         rmth_pkg::S_DONE: begin
            if (status.out_free) cmd = rmth_pkg::C_OUT;
         end
         default: cmd = rmth_pkg::C_NONE;
      endcase
   end

endmodule

// File: hdl/rmth_datapath.sv
// ----------------------------------------------------------------------------
// rmth_datapath
// Heap memories, sizes, cached tops, sift registers and the result register.
// ----------------------------------------------------------------------------
module rmth_datapath #(
   parameter int HEAP_DEPTH = rmth_pkg::DEFAULT_HEAP_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rmth_pkg::cmd_type                   cmd,
   output rmth_pkg::status_type                status,
   input  logic signed [rmth_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rmth_pkg::VALUE_W-1:0] rsp_median,
   output logic [rmth_pkg::COUNT_W-1:0]        rsp_item_count,
   output logic                                rsp_rejected
);

   localparam int IW = $clog2(HEAP_DEPTH);
   localparam int SW = $clog2(HEAP_DEPTH + 1);
   localparam int CW = SW + 1;
   localparam int VW = rmth_pkg::VALUE_W;
   localparam int KW = rmth_pkg::COUNT_W;
   localparam logic [SW-1:0] FULL_SIZE = SW'(HEAP_DEPTH);

   logic [SW-1:0] lsize_ff, usize_ff;
   logic signed [VW-1:0] ltop_ff, utop_ff;
   logic signed [VW-1:0] x_ff, pend_ff, bv_ff;
   logic [IW-1:0] idx_ff, best_ff;
   logic sel_upper_ff, two_ff, bflag_ff, rej_ff, rsp_valid_ff;
   logic signed [VW-1:0] median_ff;
   logic [KW-1:0] count_ff;

   logic we_lower, we_upper, we;
   logic [IW-1:0] waddr, raddr;
   logic signed [VW-1:0] wdata, rdata, rdata_lower, rdata_upper;

   logic is_max;
   logic [SW-1:0] size_sel;
   logic [SW:0] left_idx, right_idx;
   logic [IW-1:0] parent_idx;
   logic go_upper, bal, swap, full, lb, rb, up_move;
   logic [SW-1:0] hs, os;
   logic signed [VW-1:0] htop;
   logic [CW-1:0] sum;
   logic [CW+KW-1:0] sum_ext;
   logic signed [VW-1:0] med_now;

   assign is_max = !sel_upper_ff;
   assign size_sel = sel_upper_ff ? usize_ff : lsize_ff;
   assign left_idx = (SW+1)'({idx_ff, 1'b0}) + (SW+1)'(1);
   assign right_idx = left_idx + (SW+1)'(1);
   assign parent_idx = IW'((idx_ff - IW'(1)) >> 1);
   assign rdata = sel_upper_ff ? rdata_upper : rdata_lower;

   assign full = (lsize_ff >= FULL_SIZE) && (usize_ff >= FULL_SIZE);
   assign go_upper = (lsize_ff != '0) && !(x_ff < ltop_ff) &&
                     ((usize_ff == '0) || (x_ff > utop_ff));
   assign hs = go_upper ? usize_ff : lsize_ff;
   assign os = go_upper ? lsize_ff : usize_ff;
   assign htop = go_upper ? utop_ff : ltop_ff;
   assign bal = hs > os;
   assign swap = bal && rmth_pkg::ranks_above(htop, x_ff, !go_upper);
   assign up_move = rmth_pkg::ranks_above(x_ff, rdata, is_max);
   assign lb = rmth_pkg::ranks_above(rdata, x_ff, is_max);
   assign rb = rmth_pkg::ranks_above(rdata, bv_ff, is_max);

   always_comb begin
      status = '0;
      status.full = full;
      status.swap = swap;
      status.idx_zero = (idx_ff == '0);
      status.up_move = up_move;
      status.left_in = left_idx < {1'b0, size_sel};
      status.right_in = right_idx < {1'b0, size_sel};
      status.best_moved = bflag_ff;
      status.two_phase = two_ff;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      we = 1'b0;
      waddr = idx_ff;
      wdata = x_ff;
      raddr = idx_ff;
      case (cmd)
         rmth_pkg::C_PUSH_CHECK: begin
            if (idx_ff == '0) we = 1'b1;
            raddr = parent_idx;
         end
         rmth_pkg::C_PUSH_CMP: begin
            we = 1'b1;
            if (up_move) wdata = rdata;
         end
         rmth_pkg::C_SD_LEFT: begin
            raddr = left_idx[IW-1:0];
            if (!status.left_in) we = 1'b1;
         end
         rmth_pkg::C_SD_RIGHT: raddr = right_idx[IW-1:0];
         rmth_pkg::C_SD_MOVE: begin
            we = 1'b1;
            if (bflag_ff) wdata = bv_ff;
         end
         default: we = 1'b0;
      endcase
   end

   assign we_lower = we && !sel_upper_ff;
   assign we_upper = we && sel_upper_ff;

   rmth_ram #(.WIDTH(VW), .DEPTH(HEAP_DEPTH)) u_lower_ram (
      .clock(clock), .we(we_lower), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata_lower)
   );

   rmth_ram #(.WIDTH(VW), .DEPTH(HEAP_DEPTH)) u_upper_ram (
      .clock(clock), .we(we_upper), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata_upper)
   );

   always_ff @(posedge clock) begin
      if (we && waddr == '0) begin
         if (sel_upper_ff) utop_ff <= wdata;
         else ltop_ff <= wdata;
      end
      case (cmd)
         rmth_pkg::C_LOAD: x_ff <= req_value;
         rmth_pkg::C_PLAN: begin
            rej_ff <= full;
            two_ff <= swap;
            pend_ff <= htop;
            idx_ff <= '0;
            sel_upper_ff <= (swap || !bal) ? go_upper : !go_upper;
         end
         rmth_pkg::C_PUSH_INIT: idx_ff <= size_sel[IW-1:0];
         rmth_pkg::C_PUSH_CMP: begin
            if (up_move) idx_ff <= parent_idx;
         end
         rmth_pkg::C_SD_RIGHT: begin
            bflag_ff <= lb;
            bv_ff <= lb ? rdata : x_ff;
            best_ff <= left_idx[IW-1:0];
         end
         rmth_pkg::C_SD_RCMP: begin
            if (rb) begin
               bflag_ff <= 1'b1;
               bv_ff <= rdata;
               best_ff <= right_idx[IW-1:0];
            end
         end
         rmth_pkg::C_SD_MOVE: begin
            if (bflag_ff) idx_ff <= best_ff;
         end
         rmth_pkg::C_SWITCH: begin
            sel_upper_ff <= !sel_upper_ff;
            x_ff <= pend_ff;
            two_ff <= 1'b0;
         end
         rmth_pkg::C_OUT: begin
            median_ff <= med_now;
            count_ff <= sum_ext[KW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lsize_ff <= '0;
         usize_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd == rmth_pkg::C_PUSH_INIT) begin
            if (sel_upper_ff) usize_ff <= usize_ff + SW'(1);
            else lsize_ff <= lsize_ff + SW'(1);
         end
         if (cmd == rmth_pkg::C_OUT) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign sum = CW'(lsize_ff) + CW'(usize_ff);
   assign sum_ext = {{KW{1'b0}}, sum};
   assign med_now = (lsize_ff >= usize_ff) ?
                    ((lsize_ff != '0) ? ltop_ff : '0) : utop_ff;

   logic rsp_rej_ff;
   always_ff @(posedge clock) begin
      if (cmd == rmth_pkg::C_OUT) rsp_rej_ff <= rej_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_median = median_ff;
   assign rsp_item_count = count_ff;
   assign rsp_rejected = rsp_rej_ff;

   a_balance: assert property (@(posedge clock) disable iff (reset)
      (CW'(lsize_ff) <= CW'(usize_ff) + CW'(1)) &&
      (CW'(usize_ff) <= CW'(lsize_ff) + CW'(1)))
      else $error("heap sizes differ by more than one");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      (lsize_ff <= FULL_SIZE) && (usize_ff <= FULL_SIZE))
      else $error("heap size exceeds depth");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      (cmd == rmth_pkg::C_PUSH_INIT) |-> (size_sel < FULL_SIZE))
      else $error("push into a full heap");

endmodule

// File: hdl/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median of a signed 32-bit stream using a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Each accepted value returns one result with the current median, the count
// of held values and a rejected flag. An item passes through placement, an
// optional sift-down and a sift-up, whose pace per level is set by the
// single read port of each heap RAM. A new value is accepted only once the
// last one has handed its result on. A result that waits in the output
// register does not block the next transfer on the input side.
module running_median_two_heaps #(
   parameter int HEAP_DEPTH = rmth_pkg::DEFAULT_HEAP_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rmth_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rmth_pkg::VALUE_W-1:0] rsp_median,
   output logic [rmth_pkg::COUNT_W-1:0]        rsp_item_count,
   output logic                                rsp_rejected
);

   rmth_pkg::cmd_type    cmd;
   rmth_pkg::status_type status;

   rmth_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .status(status), .cmd(cmd)
   );

   rmth_datapath #(.HEAP_DEPTH(HEAP_DEPTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_value(req_value), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_median(rsp_median), .rsp_item_count(rsp_item_count),
      .rsp_rejected(rsp_rejected)
   );

endmodule

// File: verif/running_median_two_heaps_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_tb
// Self-checking regression of the two-heap running median.
// ----------------------------------------------------------------------------
// A predictor keeps its own max-heap and min-heap and works out the median,
// count and rejected flag of every accepted transfer. Directed values,
// random streams and a fill of the whole store up to rejection are sent in
// bursts, while the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module running_median_two_heaps_tb;

   localparam int DEPTH = rmth_pkg::DEFAULT_HEAP_DEPTH;
   localparam int VALUE_W = rmth_pkg::VALUE_W;
   localparam int COUNT_W = rmth_pkg::COUNT_W;
   localparam int LOWER = 0;
   localparam int UPPER = 1;

   typedef struct {
      logic signed [VALUE_W-1:0] median;
      logic [COUNT_W-1:0]        item_count;
      logic                      rejected;
   } median_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_median;
   logic [COUNT_W-1:0]        rsp_item_count;
   logic                      rsp_rejected;

   logic signed [VALUE_W-1:0] heaps [2][DEPTH];
   int                        sizes [2];
   median_result_type         pending_medians [$];
   int                        error_count = 0;
   int                        burst_left = 0;

   running_median_two_heaps i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_median     (rsp_median),
      .rsp_item_count (rsp_item_count),
      .rsp_rejected   (rsp_rejected)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit ranks_above(input logic signed [VALUE_W-1:0] a,
                                      input logic signed [VALUE_W-1:0] b,
                                      input bit is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

   task automatic heap_sift_down(input int h);
      int i, l, r, best;
      logic signed [VALUE_W-1:0] t;
      i = 0;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         best = i;
         if (l < sizes[h] && ranks_above(heaps[h][l], heaps[h][best], h == LOWER)) best = l;
         if (r < sizes[h] && ranks_above(heaps[h][r], heaps[h][best], h == LOWER)) best = r;
         if (best == i) return;
         t = heaps[h][i];
         heaps[h][i] = heaps[h][best];
         heaps[h][best] = t;
         i = best;
      end
   endtask

   task automatic heap_push(input int h, input logic signed [VALUE_W-1:0] x);
      int i, p;
      logic signed [VALUE_W-1:0] t;
      i = sizes[h];
      if (i >= DEPTH) return;
      heaps[h][i] = x;
      sizes[h] = i + 1;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ranks_above(heaps[h][i], heaps[h][p], h == LOWER)) break;
         t = heaps[h][i];
         heaps[h][i] = heaps[h][p];
         heaps[h][p] = t;
         i = p;
      end
   endtask

   task automatic heap_insert(input int h, input logic signed [VALUE_W-1:0] x);
      int o;
      logic signed [VALUE_W-1:0] top;
      o = 1 - h;
      if (sizes[h] > sizes[o]) begin
         top = heaps[h][0];
         if (ranks_above(top, x, h == LOWER)) begin
            heaps[h][0] = x;
            heap_sift_down(h);
            heap_push(o, top);
         end else begin
            heap_push(o, x);
         end
      end else begin
         heap_push(h, x);
      end
   endtask

   task automatic predict_median(input logic signed [VALUE_W-1:0] x,
                                 output median_result_type res);
      res.rejected = 1'b0;
      res.median = '0;
      if (sizes[LOWER] >= DEPTH && sizes[UPPER] >= DEPTH) begin
         res.rejected = 1'b1;
      end else if (sizes[LOWER] == 0 || x < heaps[LOWER][0]) begin
         heap_insert(LOWER, x);
      end else if (sizes[UPPER] == 0 || x > heaps[UPPER][0]) begin
         heap_insert(UPPER, x);
      end else begin
         heap_insert(LOWER, x);
      end
      if (sizes[LOWER] >= sizes[UPPER]) begin
         if (sizes[LOWER] > 0) res.median = heaps[LOWER][0];
      end else begin
         res.median = heaps[UPPER][0];
      end
      res.item_count = COUNT_W'(sizes[LOWER] + sizes[UPPER]);
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic send_value(input logic signed [VALUE_W-1:0] x);
      int gap;
      median_result_type res;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= x;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      predict_median(x, res);
      pending_medians.push_back(res);
   endtask

   always @(posedge clock) begin
      median_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_medians.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            exp_res = pending_medians.pop_front();
            if (rsp_median !== exp_res.median)
               report_mismatch($sformatf("median %0d, expected %0d",
                                         rsp_median, exp_res.median));
            if (rsp_item_count !== exp_res.item_count)
               report_mismatch($sformatf("item_count %0d, expected %0d",
                                         rsp_item_count, exp_res.item_count));
            if (rsp_rejected !== exp_res.rejected)
               report_mismatch($sformatf("rejected %0b, expected %0b",
                                         rsp_rejected, exp_res.rejected));
         end
      end
   end

   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic test_directed_values;
      send_value(32'sh8000_0000);
      send_value(32'sh7fff_ffff);
      send_value(0);
      send_value(-1);
      send_value(1);
      send_value(0);
      send_value(0);
      send_value(32'sh7fff_ffff);
      send_value(32'sh8000_0000);
      send_value(5);
      send_value(-5);
      send_value(3);
      send_value(3);
      send_value(-1);
      send_value(32'sh5555_5555);
      send_value(32'shaaaa_aaaa);
      send_value(2);
      send_value(1);
   endtask

   task automatic test_random_stream;
      int n, run, k;
      logic signed [VALUE_W-1:0] base;
      n = 0;
      while (n < 850) begin
         case ($urandom_range(0, 3))
            0: begin
               send_value($urandom);
               n++;
            end
            1: begin
               send_value($signed($urandom_range(0, 8)) - 4);
               n++;
            end
            default: begin
               run = $urandom_range(3, 12);
               base = $urandom;
               for (k = 0; k < run; k++) begin
                  send_value(($urandom_range(0, 1) != 0) ? base + k : base - k);
                  n++;
               end
            end
         endcase
      end
   endtask

   task automatic test_full_store;
      while (sizes[LOWER] + sizes[UPPER] < 2 * DEPTH) send_value($urandom);
      send_value(32'sh8000_0000);
      send_value(32'sh7fff_ffff);
      repeat (6) send_value($urandom);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_values();
      test_random_stream();
      test_full_store();
      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("running_median_two_heaps regression: pass");
      end else begin
         $display("running_median_two_heaps regression: fail");
      end
      $finish;
   end

   initial begin
      #(12 * 2000000);
      $display("running_median_two_heaps regression: fail");
      $finish;
   end

endmodule
